FILE: rtl/pia_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-port peripheral adapter register block.
// No dependencies.
package pia_pkg;

  localparam int NUM_UNITS_DEF = 4;
  localparam int MASK_W        = 4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EVENT = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ADDR_PORT_A = 2'd0,
    ADDR_CTRL_A = 2'd1,
    ADDR_PORT_B = 2'd2,
    ADDR_CTRL_B = 2'd3
  } reg_addr_t;

  typedef enum logic [1:0] {
    LINE_CA1 = 2'd0,
    LINE_CA2 = 2'd1,
    LINE_CB1 = 2'd2,
    LINE_CB2 = 2'd3
  } line_t;

  localparam logic [7:0] CTRL_PORT_SEL = 8'h04;
  localparam logic [7:0] CTRL_FLAG1    = 8'h80;
  localparam logic [7:0] CTRL_FLAG2    = 8'h40;
  localparam logic [7:0] CTRL_FLAG1_CLR = 8'h7f;
  localparam logic [7:0] CTRL_HS_MODE  = 8'h28;
  localparam logic [7:0] PORT_PULLUP   = 8'hff;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] unit;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
    logic [1:0] signal_line;
    logic [7:0] cable_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       cable_write;
    logic [7:0] cable_out;
    logic       cable_read;
    logic       handshake;
  } result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

FILE: rtl/pia_in_reg.sv
`timescale 1ns / 1ps
// Input register stage: captures one beat and holds it until the core advances.
// Depends on pia_pkg.
module pia_in_reg
  import pia_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  item_t      in_item,
  input  logic       advance,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic valid;
  logic valid_next;
  logic load;

  assign in_stall   = valid & ~advance;
  assign load       = in_valid & ~in_stall;
  assign valid_next = load | (valid & ~advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

  assign ctl.valid   = valid;
  assign ctl.advance = advance;

`ifndef ASSERT_OFF
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> valid)
    else $error("input stalled with empty stage");
  a_held_item: assert property (@(posedge clk) disable iff (rst)
    (valid && !advance) |=> (valid && $stable(item)))
    else $error("held item lost or changed");
`endif

endmodule

FILE: rtl/pia_core.sv
`timescale 1ns / 1ps
// Per-unit adapter registers and the single-pass read/write/event datapath.
// Depends on pia_pkg.
module pia_core
  import pia_pkg::*;
#(
  parameter int NUM_UNITS = NUM_UNITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  stage_ctl_t        ctl,
  input  item_t             item,
  input  logic [MASK_W-1:0] cable_mask,
  output result_t           res
);

  localparam int UIDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

  logic [7:0] port_a_out [NUM_UNITS];
  logic [7:0] dir_a      [NUM_UNITS];
  logic [7:0] ctrl_a     [NUM_UNITS];
  logic [7:0] port_b_out [NUM_UNITS];
  logic [7:0] dir_b      [NUM_UNITS];
  logic [7:0] ctrl_b     [NUM_UNITS];

  logic [UIDX_W-1:0] idx;
  logic              hit;
  logic              upd;
  logic              cable;
  logic [7:0]        pa, da, ca, pb, db, cb;
  logic [7:0]        ext_a;
  op_t               op;
  reg_addr_t         addr;
  line_t             line;
  result_t           calc;

  assign idx   = UIDX_W'(item.unit);
  assign hit   = (32'(item.unit) < NUM_UNITS);
  assign upd   = ctl.valid & ctl.advance & hit;
  assign cable = cable_mask[item.unit];
  assign op    = op_t'(item.op);
  assign addr  = reg_addr_t'(item.reg_addr);
  assign line  = line_t'(item.signal_line);

  assign pa = port_a_out[idx];
  assign da = dir_a[idx];
  assign ca = ctrl_a[idx];
  assign pb = port_b_out[idx];
  assign db = dir_b[idx];
  assign cb = ctrl_b[idx];

  assign ext_a = cable ? item.cable_in : PORT_PULLUP;

  always_comb begin
    calc = '0;
    unique case (op)
      OP_WRITE: begin
        if (addr == ADDR_PORT_A) begin
          if ((ca & CTRL_PORT_SEL) != '0) begin
            calc.cable_write = cable;
            calc.cable_out   = cable ? item.write_data : 8'h00;
          end else begin
            calc.cable_write = 1'b1;
            calc.cable_out   = ~item.write_data | pa;
          end
        end
      end
      OP_READ: begin
        unique case (addr)
          ADDR_PORT_A: begin
            if ((ca & CTRL_PORT_SEL) != '0) begin
              calc.cable_read = cable;
              calc.handshake  = cable & ((ca & CTRL_HS_MODE) == CTRL_HS_MODE);
              calc.read_data  = (pa & da) | (ext_a & ~da);
            end else begin
              calc.read_data = da;
            end
          end
          ADDR_CTRL_A: calc.read_data = ca;
          ADDR_PORT_B: begin
            if ((cb & CTRL_PORT_SEL) != '0) begin
              calc.read_data = (pb & db) | (PORT_PULLUP & ~db);
            end else begin
              calc.read_data = db;
            end
          end
          ADDR_CTRL_B: calc.read_data = cb;
          default: calc.read_data = 8'h00;
        endcase
      end
      OP_EVENT: calc = '0;
      OP_NOP:   calc = '0;
      default:  calc = '0;
    endcase
  end

  assign res = hit ? calc : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_UNITS; i++) begin
        port_a_out[i] <= '0;
        dir_a[i]      <= '0;
        ctrl_a[i]     <= '0;
        port_b_out[i] <= '0;
        dir_b[i]      <= '0;
        ctrl_b[i]     <= '0;
      end
    end else if (upd) begin
      unique case (op)
        OP_WRITE: begin
          unique case (addr)
            ADDR_PORT_A: begin
              if ((ca & CTRL_PORT_SEL) != '0) begin
                port_a_out[idx] <= item.write_data;
              end else begin
                dir_a[idx] <= item.write_data;
              end
            end
            ADDR_CTRL_A: ctrl_a[idx] <= item.write_data;
            ADDR_PORT_B: begin
              if ((cb & CTRL_PORT_SEL) != '0) begin
                port_b_out[idx] <= item.write_data;
              end else begin
                dir_b[idx] <= item.write_data;
              end
            end
            ADDR_CTRL_B: ctrl_b[idx] <= item.write_data;
            default: ;
          endcase
        end
        OP_READ: begin
          if (addr == ADDR_PORT_A && (ca & CTRL_PORT_SEL) != '0) begin
            ctrl_a[idx] <= ca & CTRL_FLAG1_CLR;
          end
          if (addr == ADDR_PORT_B && (cb & CTRL_PORT_SEL) != '0) begin
            ctrl_b[idx] <= cb & CTRL_FLAG1_CLR;
          end
        end
        OP_EVENT: begin
          unique case (line)
            LINE_CA1: ctrl_a[idx] <= ca | CTRL_FLAG1;
            LINE_CA2: ctrl_a[idx] <= ca | CTRL_FLAG2;
            LINE_CB1: ctrl_b[idx] <= cb | CTRL_FLAG1;
            LINE_CB2: ctrl_b[idx] <= cb | CTRL_FLAG2;
            default: ;
          endcase
        end
        OP_NOP: ;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_miss_quiet: assert property (@(posedge clk) disable iff (rst)
    !hit |-> (res == '0))
    else $error("missing unit produced a result");
  a_hs_needs_cable: assert property (@(posedge clk) disable iff (rst)
    res.handshake |-> (res.cable_read && cable))
    else $error("handshake without cable read");
  a_port_a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (upd && op == OP_READ && addr == ADDR_PORT_A && (ca & CTRL_PORT_SEL) != '0)
      |=> (ctrl_a[$past(idx)][7] == 1'b0))
    else $error("port A read left flag set");
  a_event_sets: assert property (@(posedge clk) disable iff (rst)
    (upd && op == OP_EVENT && line == LINE_CB1) |=> (ctrl_b[$past(idx)][7] == 1'b1))
    else $error("CB1 event did not set flag");
`endif

endmodule

FILE: rtl/pia_port_register_block.sv
`timescale 1ns / 1ps
// Top level: input register, adapter core and result register.
// Depends on pia_pkg, pia_in_reg, pia_core.
//
//   channel   handshake                 payload
//   in        in_valid / in_stall       op unit reg_addr write_data signal_line cable_in
//   out       out_valid / out_stall     read_data cable_write cable_out cable_read handshake
//   cfg       cfg_valid / cfg_ready     cable_enable_mask
//
// One beat per cycle while out_stall is low; out_valid is registered as its beat leaves the input register.
// Register update and result both happen as the beat leaves the input register.
// Sync reset clears all adapter registers, the cable mask and both valid flags.
// out_stall holds the result register; in_stall rises only when both stages are full.
// cfg_ready is high while the input register is empty.
module pia_port_register_block
  import pia_pkg::*;
#(
  parameter int NUM_UNITS = NUM_UNITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [1:0]        unit,
  input  logic [1:0]        reg_addr,
  input  logic [7:0]        write_data,
  input  logic [1:0]        signal_line,
  input  logic [7:0]        cable_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data,
  output logic              cable_write,
  output logic [7:0]        cable_out,
  output logic              cable_read,
  output logic              handshake,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MASK_W-1:0] cable_enable_mask
);

  item_t             in_item;
  item_t             item;
  stage_ctl_t        ctl;
  result_t           res;
  result_t           res_q;
  logic              advance;
  logic              out_valid_next;
  logic [MASK_W-1:0] cable_mask;

  assign in_item = '{op: op, unit: unit, reg_addr: reg_addr, write_data: write_data,
                     signal_line: signal_line, cable_in: cable_in};

  assign advance   = ~out_valid | ~out_stall;
  assign cfg_ready = ~ctl.valid;

  pia_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .ctl      (ctl),
    .item     (item)
  );

  pia_core #(
    .NUM_UNITS (NUM_UNITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .item       (item),
    .cable_mask (cable_mask),
    .res        (res)
  );

  assign out_valid_next = (ctl.valid & advance) | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cable_mask <= '0;
    end else begin
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        cable_mask <= cable_enable_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && advance) begin
      res_q <= res;
    end
  end

  assign read_data   = res_q.read_data;
  assign cable_write = res_q.cable_write;
  assign cable_out   = res_q.cable_out;
  assign cable_read  = res_q.cable_read;
  assign handshake   = res_q.handshake;

`ifndef ASSERT_OFF
  a_stall_only_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (ctl.valid && advance) |=> out_valid)
    else $error("advanced beat produced no result");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(res_q))
    else $error("stalled result register changed");
`endif

endmodule

FILE: verif/pia_port_register_block_tb.sv
`timescale 1ns / 1ps
// Testbench for pia_port_register_block: directed register and event checks,
// then random beats under mixed idle/stall, scored against an inline adapter model.
// Depends on pia_pkg and the pia_port_register_block RTL.
module pia_port_register_block_tb;
  import pia_pkg::*;

  localparam int UNITS        = NUM_UNITS_DEF;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 4;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       op = '0;
  logic [1:0]       unit = '0;
  logic [1:0]       reg_addr = '0;
  logic [7:0]       write_data = '0;
  logic [1:0]       signal_line = '0;
  logic [7:0]       cable_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       read_data;
  logic             cable_write;
  logic [7:0]       cable_out;
  logic             cable_read;
  logic             handshake;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [MASK_W-1:0] cable_enable_mask = '0;

  pia_port_register_block uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .unit(unit), .reg_addr(reg_addr), .write_data(write_data),
    .signal_line(signal_line), .cable_in(cable_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .cable_write(cable_write), .cable_out(cable_out),
    .cable_read(cable_read), .handshake(handshake),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cable_enable_mask(cable_enable_mask)
  );

  // adapter model state
  logic [7:0]        port_a_m [UNITS];
  logic [7:0]        dir_a_m  [UNITS];
  logic [7:0]        ctrl_a_m [UNITS];
  logic [7:0]        port_b_m [UNITS];
  logic [7:0]        dir_b_m  [UNITS];
  logic [7:0]        ctrl_b_m [UNITS];
  logic [MASK_W-1:0] cable_mask_m = '0;

  result_t pending_responses [$];
  result_t want;
  int      mismatch_count = 0;
  int      beats_sent = 0;
  int      responses_checked = 0;
  int      masks_used = 0;
  int      in_idle_pct = 0;
  int      stall_pct = 0;
  int      stuck_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic result_t adapter_response(item_t it);
    result_t    r;
    logic [7:0] ext;
    logic       attached;
    int         u;
    r        = '0;
    u        = int'(it.unit);
    attached = cable_mask_m[it.unit];
    ext      = PORT_PULLUP;
    if (u < UNITS) begin
      case (op_t'(it.op))
        OP_WRITE: begin
          case (reg_addr_t'(it.reg_addr))
            ADDR_PORT_A: begin
              if ((ctrl_a_m[u] & CTRL_PORT_SEL) != 0) begin
                if (attached) begin
                  r.cable_write = 1'b1;
                  r.cable_out   = it.write_data;
                end
                port_a_m[u] = it.write_data;
              end else begin
                r.cable_write = 1'b1;
                r.cable_out   = ~it.write_data | port_a_m[u];
                dir_a_m[u]    = it.write_data;
              end
            end
            ADDR_CTRL_A: ctrl_a_m[u] = it.write_data;
            ADDR_PORT_B: begin
              if ((ctrl_b_m[u] & CTRL_PORT_SEL) != 0) port_b_m[u] = it.write_data;
              else dir_b_m[u] = it.write_data;
            end
            ADDR_CTRL_B: ctrl_b_m[u] = it.write_data;
          endcase
        end
        OP_READ: begin
          case (reg_addr_t'(it.reg_addr))
            ADDR_PORT_A: begin
              if ((ctrl_a_m[u] & CTRL_PORT_SEL) != 0) begin
                if (attached) begin
                  r.cable_read = 1'b1;
                  r.handshake  = ((ctrl_a_m[u] & CTRL_HS_MODE) == CTRL_HS_MODE);
                  ext          = it.cable_in;
                end
                ctrl_a_m[u] = ctrl_a_m[u] & CTRL_FLAG1_CLR;
                r.read_data = (port_a_m[u] & dir_a_m[u]) | (ext & ~dir_a_m[u]);
              end else begin
                r.read_data = dir_a_m[u];
              end
            end
            ADDR_CTRL_A: r.read_data = ctrl_a_m[u];
            ADDR_PORT_B: begin
              if ((ctrl_b_m[u] & CTRL_PORT_SEL) != 0) begin
                ctrl_b_m[u] = ctrl_b_m[u] & CTRL_FLAG1_CLR;
                r.read_data = (port_b_m[u] & dir_b_m[u]) | (PORT_PULLUP & ~dir_b_m[u]);
              end else begin
                r.read_data = dir_b_m[u];
              end
            end
            ADDR_CTRL_B: r.read_data = ctrl_b_m[u];
          endcase
        end
        OP_EVENT: begin
          case (line_t'(it.signal_line))
            LINE_CA1: ctrl_a_m[u] = ctrl_a_m[u] | CTRL_FLAG1;
            LINE_CA2: ctrl_a_m[u] = ctrl_a_m[u] | CTRL_FLAG2;
            LINE_CB1: ctrl_b_m[u] = ctrl_b_m[u] | CTRL_FLAG1;
            LINE_CB2: ctrl_b_m[u] = ctrl_b_m[u] | CTRL_FLAG2;
          endcase
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // in_valid stays high after a beat; the next call either drops it or reloads the payload
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= it.op;
    unit        <= it.unit;
    reg_addr    <= it.reg_addr;
    write_data  <= it.write_data;
    signal_line <= it.signal_line;
    cable_in    <= it.cable_in;
    do @(posedge clk); while (in_stall);
    pending_responses.push_back(adapter_response(it));
    beats_sent++;
  endtask

  task automatic send_fields(input op_t o, input logic [1:0] u, input reg_addr_t a,
                             input logic [7:0] d, input line_t l, input logic [7:0] c);
    item_t it;
    it.op          = o;
    it.unit        = u;
    it.reg_addr    = a;
    it.write_data  = d;
    it.signal_line = l;
    it.cable_in    = c;
    send_item(it);
  endtask

  // sender holds off until every outstanding response is back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic set_cable_mask(input logic [MASK_W-1:0] m);
    drain();
    cfg_valid         <= 1'b1;
    cable_enable_mask <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    cable_mask_m  = m;
    masks_used++;
  endtask

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it.unit        = 2'($urandom_range(UNITS - 1));
    it.reg_addr    = 2'($urandom_range(3));
    it.write_data  = 8'($urandom_range(255));
    it.signal_line = 2'($urandom_range(3));
    it.cable_in    = 8'($urandom_range(255));
    pick           = $urandom_range(99);
    if (pick < 40) it.op = OP_WRITE;
    else if (pick < 75) it.op = OP_READ;
    else if (pick < 97) it.op = OP_EVENT;
    else it.op = OP_NOP;
    // bias control writes toward port select and handshake mode
    if (it.op == OP_WRITE && (it.reg_addr == ADDR_CTRL_A || it.reg_addr == ADDR_CTRL_B)) begin
      if ($urandom_range(3) != 0) it.write_data = it.write_data | CTRL_PORT_SEL;
      if ($urandom_range(1) != 0) it.write_data = it.write_data | CTRL_HS_MODE;
    end
    return it;
  endfunction

  task automatic test_port_a_no_cable;
    send_fields(OP_WRITE, 2'd0, ADDR_PORT_A, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_WRITE, 2'd3, ADDR_PORT_A, 8'hff, LINE_CB2, 8'hff);
    send_fields(OP_WRITE, 2'd3, ADDR_CTRL_A, 8'h2c, LINE_CA1, 8'h00);
    send_fields(OP_WRITE, 2'd3, ADDR_PORT_A, 8'ha5, LINE_CA1, 8'h5a);
    send_fields(OP_READ,  2'd3, ADDR_PORT_A, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_EVENT, 2'd3, ADDR_PORT_A, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_EVENT, 2'd3, ADDR_PORT_A, 8'h00, LINE_CA2, 8'h00);
    send_fields(OP_READ,  2'd3, ADDR_CTRL_A, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_READ,  2'd3, ADDR_PORT_A, 8'h00, LINE_CA1, 8'hff);
    send_fields(OP_READ,  2'd3, ADDR_CTRL_A, 8'h00, LINE_CA1, 8'h00);
  endtask

  task automatic test_port_b;
    send_fields(OP_WRITE, 2'd1, ADDR_PORT_B, 8'h0f, LINE_CA1, 8'h00);
    send_fields(OP_WRITE, 2'd1, ADDR_CTRL_B, 8'h04, LINE_CA1, 8'h00);
    send_fields(OP_WRITE, 2'd1, ADDR_PORT_B, 8'h5a, LINE_CA1, 8'h00);
    send_fields(OP_EVENT, 2'd1, ADDR_PORT_B, 8'h00, LINE_CB1, 8'h00);
    send_fields(OP_EVENT, 2'd1, ADDR_PORT_B, 8'h00, LINE_CB2, 8'h00);
    send_fields(OP_READ,  2'd1, ADDR_PORT_B, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_READ,  2'd1, ADDR_CTRL_B, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_WRITE, 2'd1, ADDR_CTRL_B, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_READ,  2'd1, ADDR_PORT_B, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_NOP,   2'd2, ADDR_CTRL_B, 8'hff, LINE_CB2, 8'hff);
  endtask

  task automatic test_cable_handshake;
    set_cable_mask(4'hf);
    send_fields(OP_READ,  2'd3, ADDR_PORT_A, 8'h00, LINE_CA1, 8'h00);
    send_fields(OP_READ,  2'd3, ADDR_PORT_A, 8'h00, LINE_CA1, 8'hff);
    send_fields(OP_WRITE, 2'd3, ADDR_PORT_A, 8'h3c, LINE_CA1, 8'h00);
    send_fields(OP_WRITE, 2'd3, ADDR_CTRL_A, 8'h24, LINE_CA1, 8'h00);
    send_fields(OP_READ,  2'd3, ADDR_PORT_A, 8'h00, LINE_CA1, 8'h96);
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall,
                                   input logic [MASK_W-1:0] m);
    set_cable_mask(m);
    in_idle_pct = idle;
    stall_pct   = stall;
    repeat (n) send_item(random_item());
    in_idle_pct = 0;
    stall_pct   = 0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $error("response with none outstanding");
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        responses_checked++;
        if (read_data !== want.read_data) begin
          $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, read_data);
          mismatch_count++;
        end
        if (cable_write !== want.cable_write) begin
          $error("cable_write: expected %0b, got %0b", want.cable_write, cable_write);
          mismatch_count++;
        end
        if (cable_out !== want.cable_out) begin
          $error("cable_out: expected 0x%02h, got 0x%02h", want.cable_out, cable_out);
          mismatch_count++;
        end
        if (cable_read !== want.cable_read) begin
          $error("cable_read: expected %0b, got %0b", want.cable_read, cable_read);
          mismatch_count++;
        end
        if (handshake !== want.handshake) begin
          $error("handshake: expected %0b, got %0b", want.handshake, handshake);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < UNITS; i++) begin
      port_a_m[i] = '0;
      dir_a_m[i]  = '0;
      ctrl_a_m[i] = '0;
      port_b_m[i] = '0;
      dir_b_m[i]  = '0;
      ctrl_b_m[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_port_a_no_cable();
    test_port_b();
    test_cable_handshake();
    test_random_phase(380, 0, 0, 4'h0);
    test_random_phase(380, 69, 0, 4'hf);
    test_random_phase(380, 0, 69, MASK_W'($urandom_range(15)));
    test_random_phase(380, 31, 31, 4'h5);
    test_random_phase(380, 0, 0, 4'ha);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d beats over %0d cable masks and four idle/stall mixes.",
             beats_sent, masks_used);
    $display("Checked %0d responses, %0d field mismatches.", responses_checked,
             mismatch_count);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
